>>> rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared codes and widths of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned STRIDE_W = 11;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned REQ_SLOT_W = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned DIV_STEP_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC      = 3'd0,
      OP_FREE_SLOT  = 3'd1,
      OP_FREE_ADDR  = 3'd2,
      OP_QUERY      = 3'd3,
      OP_TRANSLATE  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EXHAUSTED  = 3'd1,
      ST_BAD_FREE   = 3'd2,
      ST_BELOW      = 3'd3,
      ST_MISALIGNED = 3'd4,
      ST_RANGE      = 3'd5,
      ST_NOINIT     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      REG_CPU_BASE = 2'd0,
      REG_GPU_BASE = 2'd1,
      REG_STRIDE   = 2'd2
   } reg_index_type;

endpackage

>>> rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Hands out descriptor slots from a LIFO free stack or a bump pointer, frees
// them by slot number or by CPU address, answers capacity queries and
// translates slots into CPU and GPU addresses.
// ----------------------------------------------------------------------------
// from accept to result valid: query and early errors go straight to done,
// allocate via set-held (bump) or pop, pop-latch, set-held (stack pop),
// free slot via read and check, translate via multiply and add, address
// free via the 64-step restoring divider sharing one subtractor, then read
// and check; one item in flight, but the next is taken while a result waits
// synchronous reset clears control state and registers; the held bits are
// only read below the bump pointer, so no clearing pass runs after reset
// ----------------------------------------------------------------------------
module descriptor_slot_allocator #(
   parameter int unsigned SLOT_COUNT = 512,
   localparam int unsigned SLOT_W = $clog2(SLOT_COUNT)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dsa_pkg::OP_W-1:0]               req_operation,
   input  logic [dsa_pkg::REQ_SLOT_W-1:0]         req_slot_number,
   input  logic [dsa_pkg::ADDR_W-1:0]             req_cpu_address,
   input  logic [dsa_pkg::COUNT_W-1:0]            req_wanted_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dsa_pkg::STATUS_W-1:0]           rsp_status,
   output logic [SLOT_W-1:0]                      rsp_granted_slot,
   output logic [dsa_pkg::ADDR_W-1:0]             rsp_cpu_handle,
   output logic [dsa_pkg::ADDR_W-1:0]             rsp_gpu_handle,
   output logic                                   rsp_fits,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [dsa_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [dsa_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [dsa_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int unsigned PROD_W = dsa_pkg::STRIDE_W + SLOT_W;
   localparam int unsigned REM_W  = dsa_pkg::STRIDE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_POP_LATCH,
      S_SET_HELD,
      S_REL_RD,
      S_REL_CHK,
      S_DIV,
      S_DIV_CHK,
      S_MUL,
      S_ADD,
      S_DONE
   } state_type;

   state_type                        state_ff;
   logic [CNT_W-1:0]                 depth_ff;
   logic [CNT_W-1:0]                 bump_ff;
   logic [SLOT_W-1:0]                slot_ff;
   logic                             addr_free_ff;
   logic [dsa_pkg::ADDR_W-1:0]       off_ff;
   logic [REM_W-1:0]                 rem_ff;
   logic [CNT_W-1:0]                 quot_ff;
   logic                             quot_big_ff;
   logic [dsa_pkg::DIV_STEP_W-1:0]   step_ff;
   logic [PROD_W-1:0]                prod_ff;

   dsa_pkg::status_type              res_status_ff;
   logic [SLOT_W-1:0]                res_granted_ff;
   logic [dsa_pkg::ADDR_W-1:0]       res_cpu_ff;
   logic [dsa_pkg::ADDR_W-1:0]       res_gpu_ff;
   logic                             res_fits_ff;

   logic                             rsp_valid_ff;
   logic [dsa_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [SLOT_W-1:0]                rsp_granted_ff;
   logic [dsa_pkg::ADDR_W-1:0]       rsp_cpu_ff;
   logic [dsa_pkg::ADDR_W-1:0]       rsp_gpu_ff;
   logic                             rsp_fits_ff;

   logic [dsa_pkg::ADDR_W-1:0]       cpu_base_ff;
   logic [dsa_pkg::ADDR_W-1:0]       gpu_base_ff;
   logic [dsa_pkg::STRIDE_W-1:0]     stride_ff;

   // free stack and held map memories
   logic [SLOT_W-1:0]                free_stack [SLOT_COUNT];
   logic                             held_map [SLOT_COUNT];
   logic [SLOT_W-1:0]                stack_q_ff;
   logic                             held_q_ff;

   logic                             held_we;
   logic                             held_wdata;
   logic                             stack_we;
   logic                             accept;
   logic                             csr_write;
   logic                             rsp_load;
   logic [REM_W:0]                   div_trial;
   logic [REM_W:0]                   div_diff;
   logic                             div_ge;

   dsa_pkg::status_type              start_status_in;
   state_type                        start_state_in;
   logic                             start_fits_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // one restoring divider step per cycle
   assign div_trial = {rem_ff, off_ff[dsa_pkg::ADDR_W-1]};
   assign div_ge    = (div_trial >= {1'b0, stride_ff});
   assign div_diff  = div_trial - {1'b0, stride_ff};

   assign held_we    = (state_ff == S_SET_HELD) || ((state_ff == S_REL_CHK) && held_q_ff);
   assign held_wdata = (state_ff == S_SET_HELD);
   assign stack_we   = (state_ff == S_REL_CHK) && held_q_ff
                       && (32'(depth_ff) < 32'(SLOT_COUNT));

   // status, next state and fit of a request taken in idle
   always_comb begin
      start_status_in = dsa_pkg::ST_OK;
      start_state_in  = S_DONE;
      start_fits_in   = 1'b0;
      unique case (dsa_pkg::op_type'(req_operation))
         dsa_pkg::OP_ALLOC: begin
            if (depth_ff != '0) begin
               start_state_in = S_POP;
            end else if (32'(bump_ff) >= 32'(SLOT_COUNT)) begin
               start_status_in = dsa_pkg::ST_EXHAUSTED;
            end else begin
               start_state_in = S_SET_HELD;
            end
         end
         dsa_pkg::OP_FREE_SLOT: begin
            if (32'(req_slot_number) >= 32'(bump_ff)) begin
               start_status_in = dsa_pkg::ST_BAD_FREE;
            end else begin
               start_state_in = S_REL_RD;
            end
         end
         dsa_pkg::OP_FREE_ADDR: begin
            if (stride_ff == '0) begin
               start_status_in = dsa_pkg::ST_NOINIT;
            end else if (req_cpu_address < cpu_base_ff) begin
               start_status_in = dsa_pkg::ST_BELOW;
            end else begin
               start_state_in = S_DIV;
            end
         end
         dsa_pkg::OP_QUERY: begin
            start_fits_in = (32'(req_wanted_count)
                             <= 32'(depth_ff) + 32'(SLOT_COUNT) - 32'(bump_ff));
         end
         dsa_pkg::OP_TRANSLATE: begin
            if (stride_ff == '0) begin
               start_status_in = dsa_pkg::ST_NOINIT;
            end else if (32'(req_slot_number) >= 32'(SLOT_COUNT)) begin
               start_status_in = dsa_pkg::ST_RANGE;
            end else begin
               start_state_in = S_MUL;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_map[slot_ff] <= held_wdata;
      end
      held_q_ff <= held_map[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         free_stack[depth_ff[SLOT_W-1:0]] <= slot_ff;
      end
      stack_q_ff <= free_stack[depth_ff[SLOT_W-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         stride_ff   <= '0;
      end else if (csr_write) begin
         unique case (paddr[4:3])
            dsa_pkg::REG_CPU_BASE: cpu_base_ff <= pwdata;
            dsa_pkg::REG_GPU_BASE: gpu_base_ff <= pwdata;
            dsa_pkg::REG_STRIDE:   stride_ff   <= pwdata[dsa_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         dsa_pkg::REG_CPU_BASE: prdata = cpu_base_ff;
         dsa_pkg::REG_GPU_BASE: prdata = gpu_base_ff;
         dsa_pkg::REG_STRIDE:   prdata = dsa_pkg::CSR_DATA_W'(stride_ff);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_status_ff  <= start_status_in;
                  res_granted_ff <= '0;
                  res_cpu_ff     <= '0;
                  res_gpu_ff     <= '0;
                  res_fits_ff    <= start_fits_in;
                  addr_free_ff   <= (req_operation == dsa_pkg::OP_FREE_ADDR);
                  state_ff       <= start_state_in;
                  unique case (dsa_pkg::op_type'(req_operation))
                     dsa_pkg::OP_ALLOC: begin
                        if (depth_ff != '0) begin
                           depth_ff <= depth_ff - CNT_W'(1);
                        end else if (32'(bump_ff) < 32'(SLOT_COUNT)) begin
                           slot_ff <= bump_ff[SLOT_W-1:0];
                           bump_ff <= bump_ff + CNT_W'(1);
                        end
                     end
                     dsa_pkg::OP_FREE_SLOT, dsa_pkg::OP_TRANSLATE: begin
                        slot_ff <= req_slot_number[SLOT_W-1:0];
                     end
                     dsa_pkg::OP_FREE_ADDR: begin
                        off_ff      <= req_cpu_address - cpu_base_ff;
                        rem_ff      <= '0;
                        quot_ff     <= '0;
                        quot_big_ff <= 1'b0;
                        step_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_POP: begin
               state_ff <= S_POP_LATCH;
            end
            S_POP_LATCH: begin
               slot_ff  <= stack_q_ff;
               state_ff <= S_SET_HELD;
            end
            S_SET_HELD: begin
               res_granted_ff <= slot_ff;
               state_ff       <= S_DONE;
            end
            S_REL_RD: begin
               state_ff <= S_REL_CHK;
            end
            S_REL_CHK: begin
               if (held_q_ff) begin
                  if (stack_we) begin
                     depth_ff <= depth_ff + CNT_W'(1);
                  end
                  if (addr_free_ff) begin
                     res_granted_ff <= slot_ff;
                  end
               end else begin
                  res_status_ff <= dsa_pkg::ST_BAD_FREE;
               end
               state_ff <= S_DONE;
            end
            S_DIV: begin
               rem_ff      <= div_ge ? div_diff[REM_W-1:0] : div_trial[REM_W-1:0];
               quot_ff     <= {quot_ff[CNT_W-2:0], div_ge};
               quot_big_ff <= quot_big_ff | quot_ff[CNT_W-1];
               off_ff      <= {off_ff[dsa_pkg::ADDR_W-2:0], 1'b0};
               step_ff     <= step_ff + dsa_pkg::DIV_STEP_W'(1);
               if (step_ff == '1) begin
                  state_ff <= S_DIV_CHK;
               end
            end
            S_DIV_CHK: begin
               if (rem_ff != '0) begin
                  res_status_ff <= dsa_pkg::ST_MISALIGNED;
                  state_ff      <= S_DONE;
               end else if (quot_big_ff || (quot_ff >= bump_ff)) begin
                  res_status_ff <= dsa_pkg::ST_BAD_FREE;
                  state_ff      <= S_DONE;
               end else begin
                  slot_ff  <= quot_ff[SLOT_W-1:0];
                  state_ff <= S_REL_RD;
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(stride_ff) * PROD_W'(slot_ff);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               res_cpu_ff <= cpu_base_ff + dsa_pkg::ADDR_W'(prod_ff);
               res_gpu_ff <= gpu_base_ff + dsa_pkg::ADDR_W'(prod_ff);
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_status_ff  <= res_status_ff;
                  rsp_granted_ff <= res_granted_ff;
                  rsp_cpu_ff     <= res_cpu_ff;
                  rsp_gpu_ff     <= res_gpu_ff;
                  rsp_fits_ff    <= res_fits_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_cpu_handle   = rsp_cpu_ff;
   assign rsp_gpu_handle   = rsp_gpu_ff;
   assign rsp_fits         = rsp_fits_ff;

endmodule

>>> rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks on the result channel of the descriptor slot allocator.
// ----------------------------------------------------------------------------
module dsa_checker #(
   parameter int unsigned SLOT_COUNT = 512,
   localparam int unsigned SLOT_W = $clog2(SLOT_COUNT)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dsa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [SLOT_W-1:0]             rsp_granted_slot,
   input logic [dsa_pkg::ADDR_W-1:0]    rsp_cpu_handle,
   input logic [dsa_pkg::ADDR_W-1:0]    rsp_gpu_handle,
   input logic                          rsp_fits
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_slot) && $stable(rsp_cpu_handle)
         && $stable(rsp_gpu_handle) && $stable(rsp_fits))
      else $error("result beat changed while stalled");

   // an error beat carries no slot, handle or fit
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dsa_pkg::ST_OK) |->
         (rsp_granted_slot == '0) && (rsp_cpu_handle == '0)
         && (rsp_gpu_handle == '0) && !rsp_fits)
      else $error("error beat carries payload");

   // nothing in flight right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block busy after reset");

   // an accepted request cannot be followed at once by another accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

endmodule

bind descriptor_slot_allocator dsa_checker #(
   .SLOT_COUNT(SLOT_COUNT)
) u_dsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_cpu_handle   (rsp_cpu_handle),
   .rsp_gpu_handle   (rsp_gpu_handle),
   .rsp_fits         (rsp_fits)
);
